// ===== rtl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the complex magnitude sorter.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int DATA_W        = 16;
  localparam int KEY_W         = 32;
  localparam int ENTRY_W       = 2 * DATA_W + KEY_W;
  localparam int MAX_ITEMS_DEF = 64;

  // one stored number, key in the low bits
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [KEY_W-1:0]         key;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_CMP   = 6'b000100,
    S_PLACE = 6'b001000,
    S_OUT   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

endpackage

// ===== rtl/cms_ram.sv =====
// ----------------------------------------------------------------------------
// cms_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cms_mag.sv =====
// ----------------------------------------------------------------------------
// cms_mag
// Two-stage squared magnitude: registered squares, then registered sum.
// ----------------------------------------------------------------------------
module cms_mag import cms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [DATA_W-1:0] re,
  input  logic signed [DATA_W-1:0] im,
  output logic                     key_valid,
  output logic [KEY_W-1:0]         key
);

  logic signed [2*DATA_W-1:0] prod_re;
  logic signed [2*DATA_W-1:0] prod_im;
  logic [KEY_W-1:0]           sq_re;
  logic [KEY_W-1:0]           sq_im;
  logic                       sq_valid;

  assign prod_re = re * re;
  assign prod_im = im * im;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      key_valid <= 1'b0;
    end else begin
      sq_valid  <= go;
      key_valid <= sq_valid;
    end
  end

  // squares are at most 2^30, so their sum fits 32 bits unsigned
  always_ff @(posedge clk) begin
    sq_re <= KEY_W'(unsigned'(prod_re));
    sq_im <= KEY_W'(unsigned'(prod_im));
    key   <= sq_re + sq_im;
  end

endmodule

// ===== rtl/complex_magnitude_sorter.sv =====
// ----------------------------------------------------------------------------
// complex_magnitude_sorter
// Collects a batch of complex numbers, keeps them ordered by squared
// magnitude in a RAM and plays the batch out in ascending order.
// ----------------------------------------------------------------------------
// An item transfers when start is high and busy is low. Each number is held
// in one RAM entry and inserted in order as it arrives: once its key has
// formed in cms_mag, every stored entry with a larger key is moved up one
// place, one entry per cycle through the single read port, and busy stays
// high until the number is placed. A number that arrives at a full store is
// dropped; busy rises for it only if it is marked batch_end. Equal keys stay
// in arrival order. Once the store holds MAX_ITEMS numbers, further numbers
// are dropped and overflow is set on every result of that batch. On the item
// marked batch_end the whole batch follows, one result per cycle on
// consecutive cycles with strobe high, once the last number is placed or
// dropped; final_result marks the last one. Busy stays high until the
// last result is out. Results cannot be held off and must be taken in the
// cycle they appear. No clearing pass is needed after reset.
module complex_magnitude_sorter import cms_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] real_part,
  input  logic signed [DATA_W-1:0] imag_part,
  input  logic                     batch_end,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] sorted_real,
  output logic signed [DATA_W-1:0] sorted_imag,
  output logic [KEY_W-1:0]         magnitude_squared,
  output logic                     final_result,
  output logic                     overflow
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  idx;
  logic              dropped;
  logic              last;
  entry_t            item;
  logic              final_next;

  logic              accept;
  logic              full;
  logic              mag_go;
  logic              key_valid;
  logic [KEY_W-1:0]  key;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;

  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  pos_m2;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign mag_go   = accept && !full;
  assign count_m1 = count - CNT_W'(1);
  assign pos_m1   = pos - CNT_W'(1);
  assign pos_m2   = pos - CNT_W'(2);

  cms_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .go        (mag_go),
    .re        (real_part),
    .im        (imag_part),
    .key_valid (key_valid),
    .key       (key)
  );

  cms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read address and write port
  always_comb begin
    raddr = count_m1[ADDR_W-1:0];
    we    = 1'b0;
    waddr = pos[ADDR_W-1:0];
    wdata = item;
    case (state)
      S_KEY: begin
        raddr = count_m1[ADDR_W-1:0];
      end
      S_CMP: begin
        raddr = pos_m2[ADDR_W-1:0];
        if (rdata.key > item.key) begin
          we    = 1'b1;
          wdata = rdata;
        end
      end
      S_PLACE: begin
        we = 1'b1;
      end
      S_OUT: begin
        raddr = idx[ADDR_W-1:0];
      end
      default: begin
        raddr = count_m1[ADDR_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
              if (batch_end) begin
                state <= S_OUT;
              end
            end else begin
              state <= S_KEY;
            end
          end
        end
        S_KEY: begin
          if (key_valid) begin
            state <= (count == '0) ? S_PLACE : S_CMP;
          end
        end
        S_CMP: begin
          // entry at pos-1 is on rdata; shift it up while its key is larger
          if (rdata.key > item.key) begin
            if (pos_m1 == '0) begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= last ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          strobe <= 1'b1;
          if (idx == count_m1) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          count   <= '0;
          dropped <= 1'b0;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign final_next = (idx == count_m1);

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item.re <= real_part;
      item.im <= imag_part;
      last    <= batch_end;
    end
    if (state == S_KEY && key_valid) begin
      item.key <= key;
      pos      <= count;
    end
    if (state == S_CMP && rdata.key > item.key) begin
      pos <= pos_m1;
    end
    if (state == S_OUT) begin
      idx          <= idx + CNT_W'(1);
      final_result <= final_next;
    end else begin
      idx          <= '0;
      final_result <= 1'b0;
    end
  end

  assign sorted_real       = rdata.re;
  assign sorted_imag       = rdata.im;
  assign magnitude_squared = rdata.key;
  assign overflow          = dropped;

endmodule

// ===== rtl/cms_checker.sv =====
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks on the sorter's result sequence, bound to the top level.
// ----------------------------------------------------------------------------
module cms_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic final_result
);

  // results only come out while the block is working on a batch
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe while not busy");

  a_final_strobe: assert property (@(posedge clk) disable iff (rst)
    final_result |-> strobe)
    else $error("final_result without strobe");

  // a batch plays out on consecutive cycles
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !final_result |=> strobe)
    else $error("gap inside result burst");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    strobe && final_result |=> !strobe)
    else $error("result after final_result");

  // an item transfer never produces a result in the very next cycle
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("result right after transfer");

endmodule

bind complex_magnitude_sorter cms_checker u_cms_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .final_result (final_result)
);

// ===== sim/complex_magnitude_sorter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_magnitude_sorter_tb
// Self-checking bench for the magnitude sorter. Directed batches hit the
// extreme values, equal keys and reversed arrival order. Random batches follow,
// among them one that fills the store exactly and one that overflows it.
// Every accepted number goes through a local model of the sorted store, and
// each strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module complex_magnitude_sorter_tb import cms_pkg::*;;

  localparam int CAPACITY     = MAX_ITEMS_DEF;
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PERCENT = 26;
  localparam int RANDOM_ITEMS = 140;
  localparam int FILL_AFTER   = 8;
  localparam int QUIET_FIRST  = 60;
  localparam int QUIET_LAST   = 130;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } number_t;

  typedef struct {
    entry_t number;
    logic   last;
    logic   dropped;
  } sorted_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] real_part = '0;
  logic signed [DATA_W-1:0] imag_part = '0;
  logic                     batch_end = 1'b0;
  logic                     strobe;
  logic signed [DATA_W-1:0] sorted_real;
  logic signed [DATA_W-1:0] sorted_imag;
  logic [KEY_W-1:0]         magnitude_squared;
  logic                     final_result;
  logic                     overflow;

  number_t pending_numbers[$];
  sorted_t expected_results[$];
  entry_t  batch_store[$];
  logic    batch_dropped = 1'b0;
  number_t on_ports;
  int      numbers_queued = 0;
  int      numbers_sent = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  complex_magnitude_sorter #(
    .MAX_ITEMS(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .real_part(real_part),
    .imag_part(imag_part),
    .batch_end(batch_end),
    .strobe(strobe),
    .sorted_real(sorted_real),
    .sorted_imag(sorted_imag),
    .magnitude_squared(magnitude_squared),
    .final_result(final_result),
    .overflow(overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [KEY_W-1:0] squared_magnitude(logic signed [DATA_W-1:0] re,
                                                         logic signed [DATA_W-1:0] im);
    int ar;
    int ai;
    ar = (re < 0) ? -int'(re) : int'(re);
    ai = (im < 0) ? -int'(im) : int'(im);
    // each square fits in an int, the sum of two only in 32 unsigned bits
    return KEY_W'(ar * ar) + KEY_W'(ai * ai);
  endfunction

  // place a number behind every stored key not above its own; emit on batch end
  task automatic track_number(number_t num);
    entry_t  e;
    sorted_t r;
    int      pos;
    if (batch_store.size() < CAPACITY) begin
      e.re  = num.re;
      e.im  = num.im;
      e.key = squared_magnitude(num.re, num.im);
      pos = batch_store.size();
      while (pos > 0 && batch_store[pos-1].key > e.key) pos--;
      batch_store.insert(pos, e);
    end else begin
      batch_dropped = 1'b1;
    end
    if (num.last) begin
      foreach (batch_store[i]) begin
        r.number  = batch_store[i];
        r.last    = (i == batch_store.size() - 1);
        r.dropped = batch_dropped;
        expected_results.push_back(r);
      end
      batch_store.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // driver: one transfer per edge with start high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        track_number(on_ports);
        numbers_sent++;
      end
      if (!(start && busy)) begin
        if (pending_numbers.size() > 0 &&
            ((numbers_sent >= QUIET_FIRST && numbers_sent < QUIET_LAST) ||
             $urandom_range(99) >= IDLE_PERCENT)) begin
          on_ports = pending_numbers.pop_front();
          real_part <= on_ports.re;
          imag_part <= on_ports.im;
          batch_end <= on_ports.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be stalled, take one whenever strobe is high
  always @(posedge clk) begin : monitor
    sorted_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result re %0d im %0d mag %0d",
                                  sorted_real, sorted_imag, magnitude_squared));
      end else begin
        want = expected_results.pop_front();
        if (sorted_real !== want.number.re)
          report_mismatch($sformatf("sorted_real %0d, want %0d", sorted_real, want.number.re));
        if (sorted_imag !== want.number.im)
          report_mismatch($sformatf("sorted_imag %0d, want %0d", sorted_imag, want.number.im));
        if (magnitude_squared !== want.number.key)
          report_mismatch($sformatf("magnitude_squared %0d, want %0d",
                                    magnitude_squared, want.number.key));
        if (final_result !== want.last)
          report_mismatch($sformatf("final_result %b, want %b", final_result, want.last));
        if (overflow !== want.dropped)
          report_mismatch($sformatf("overflow %b, want %b", overflow, want.dropped));
      end
    end
  end

  task automatic queue_number(int re, int im, bit last);
    number_t num;
    num.re   = DATA_W'(re);
    num.im   = DATA_W'(im);
    num.last = last;
    pending_numbers.push_back(num);
    numbers_queued++;
  endtask

  // mix of small values (many equal keys), extremes and full-range noise
  function automatic int random_part();
    case ($urandom_range(3))
      0: return int'($urandom_range(8)) - 4;
      1: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic queue_batch(int count);
    for (int i = 0; i < count; i++)
      queue_number(random_part(), random_part(), i == count - 1);
  endtask

  initial begin
    int random_count;
    int batch_len;
    bit filled;
    bit overflowed;

    // single number batch
    queue_number(0, 0, 1);
    // extremes, largest key first in arrival and last in sorted order
    queue_number(-32768, -32768, 0);
    queue_number(32767, 32767, 0);
    queue_number(-32768, 0, 0);
    queue_number(0, -32768, 0);
    queue_number(1, 0, 0);
    queue_number(0, 1, 0);
    queue_number(-1, -1, 0);
    queue_number(32767, -32768, 1);
    // equal keys keep arrival order, zero closes the batch and sorts first
    queue_number(3, 4, 0);
    queue_number(4, 3, 0);
    queue_number(-3, -4, 0);
    queue_number(5, 0, 0);
    queue_number(0, -5, 0);
    queue_number(0, 0, 1);
    // descending arrival shifts every stored entry
    queue_number(100, 0, 0);
    queue_number(50, 0, 0);
    queue_number(10, 0, 0);
    queue_number(-1, 0, 1);

    random_count = 0;
    filled = 1'b0;
    overflowed = 1'b0;
    while (random_count < RANDOM_ITEMS) begin
      if (random_count >= FILL_AFTER && !filled) begin
        // store filled exactly, end mark on the last stored number
        batch_len = CAPACITY;
        filled = 1'b1;
      end else if (filled && !overflowed) begin
        // end mark lands on a dropped number
        batch_len = CAPACITY + $urandom_range(1, 4);
        overflowed = 1'b1;
      end else begin
        batch_len = $urandom_range(1, 10);
      end
      queue_batch(batch_len);
      random_count += batch_len;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (numbers_sent != numbers_queued) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cms_pkg.sv
rtl/cms_ram.sv
rtl/cms_mag.sv
rtl/complex_magnitude_sorter.sv
rtl/cms_checker.sv
sim/complex_magnitude_sorter_tb.sv
